[rtl/segment_cell_face_crossing_macros.svh]
// Assertion macros shared by the face crossing block.
`ifndef SEGMENT_CELL_FACE_CROSSING_MACROS_SVH
`define SEGMENT_CELL_FACE_CROSSING_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SCFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scfc assertion failed");

// Check that cons holds in the cycle after ante.
`define SCFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scfc assertion failed");

`endif

[rtl/scfc_pkg.sv]
// Package with widths, types and constants of the face crossing block.
package scfc_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int PARAM_FRAC_BITS = 24;

  localparam int NAX = 3;                 // axes
  localparam int CW  = 32;                // coordinate width
  localparam int SW  = 31;                // size register width
  localparam int CIW = 2;                 // config index width
  localparam int DVW = CW + 1;            // segment vector width
  localparam int DW  = CW + 3;            // numerator / denominator width
  localparam int QW  = PARAM_FRAC_BITS + 1;  // quotient magnitude width
  localparam int SGW = QW + 1;            // signed parameter width
  localparam int MW  = CW + 2;            // product magnitude width
  localparam int HW  = MW + 2;            // unsaturated hit width
  localparam int PW  = CW + PARAM_FRAC_BITS;  // fraction product width
  localparam int NST = QW + 4;            // pipeline depth

  localparam logic [SW-1:0] SIZE_RST = SW'(1 << COORD_FRAC_BITS);
  localparam int S_TOL = ((1 << PARAM_FRAC_BITS) + 500000) / 1000000;
  localparam logic signed [SGW-1:0] S_LO = SGW'(-S_TOL);
  localparam logic signed [SGW-1:0] S_HI = SGW'((1 << PARAM_FRAC_BITS) + S_TOL);

  typedef enum logic [CIW-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FACE_XMIN = 3'd0,
    FACE_XMAX = 3'd1,
    FACE_YMIN = 3'd2,
    FACE_YMAX = 3'd3,
    FACE_ZMIN = 3'd4,
    FACE_ZMAX = 3'd5
  } face_e;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic ok;    // face candidate survives den and range checks
    logic neg;   // numerator negative
    logic odd;   // max face of the axis
  } tag_t;

  typedef struct packed {
    tag_t            tag;
    logic [DW-1:0]   n;
    logic [DW-1:0]   d;
  } lane_t;

  typedef struct packed {
    tag_t            tag;
    logic [QW-1:0]   q;
  } quo_t;

  typedef struct packed {
    logic signed [CW-1:0]  st;
    logic signed [DVW-1:0] dv;
  } axis_t;

  typedef axis_t [NAX-1:0] segd_t;

  typedef struct packed {
    logic                  found;
    face_e                 face;
    logic signed [SGW-1:0] s;
    segd_t                 seg;
  } pick_t;

endpackage

[rtl/scfc_if.sv]
// Stream interfaces for segment words and hit words.
interface scfc_seg_if;
  logic                          valid;
  logic                          ready;
  logic signed [scfc_pkg::CW-1:0] start_x;
  logic signed [scfc_pkg::CW-1:0] start_y;
  logic signed [scfc_pkg::CW-1:0] start_z;
  logic signed [scfc_pkg::CW-1:0] end_x;
  logic signed [scfc_pkg::CW-1:0] end_y;
  logic signed [scfc_pkg::CW-1:0] end_z;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

interface scfc_hit_if;
  logic                          valid;
  logic                          ready;
  logic                          crossed;
  logic [2:0]                    side_index;
  logic signed [scfc_pkg::CW-1:0] hit_x;
  logic signed [scfc_pkg::CW-1:0] hit_y;
  logic signed [scfc_pkg::CW-1:0] hit_z;
  modport source (output valid, crossed, side_index, hit_x, hit_y, hit_z,
                  input ready);
  modport sink   (input valid, crossed, side_index, hit_x, hit_y, hit_z,
                  output ready);
endinterface

[rtl/segment_cell_face_crossing.sv]
// Top level of the segment / cell face crossing pipeline.
// One segment word is taken per clock unless the output word is held; each passes
// through setup, one divider stage per quotient bit, face select, multiply, add and
// saturate, and gives one hit word. A held output word freezes the whole pipeline,
// and ready follows from the output side in the same cycle. Size registers are to be
// written by the user through the config port while idle; the block does not enforce it.
`include "segment_cell_face_crossing_macros.svh"

module segment_cell_face_crossing (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [scfc_pkg::CIW-1:0] cfg_idx_i,
  input  logic [scfc_pkg::SW-1:0]  cfg_data_i,
  scfc_seg_if.sink                 seg,
  scfc_hit_if.source               hit
);

  logic                                  adv;
  logic [scfc_pkg::NST-1:0]              vld_q;
  scfc_pkg::coord_t [scfc_pkg::NAX-1:0]  st_in;
  scfc_pkg::coord_t [scfc_pkg::NAX-1:0]  end_in;
  scfc_pkg::lane_t  [scfc_pkg::NAX-1:0]  lane;
  scfc_pkg::quo_t   [scfc_pkg::NAX-1:0]  quo;
  scfc_pkg::segd_t                       sb;
  scfc_pkg::segd_t                       sbd_q [scfc_pkg::QW];
  scfc_pkg::pick_t                       pick;
  scfc_pkg::coord_t [scfc_pkg::NAX-1:0]  hit_c;
  logic [2:0]                            side;
  logic                                  crossed;
  logic                                  miss_zero;

  // Advance everything unless the output word is held
  assign adv       = !vld_q[scfc_pkg::NST-1] || hit.ready;
  assign seg.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[scfc_pkg::NST-2:0], seg.valid};
    end
  end

  assign st_in  = {seg.start_z, seg.start_y, seg.start_x};
  assign end_in = {seg.end_z, seg.end_y, seg.end_x};

  scfc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .st_i       (st_in),
    .end_i      (end_in),
    .lane_o     (lane),
    .sb_o       (sb)
  );

  for (genvar a = 0; a < scfc_pkg::NAX; a++) begin : g_div
    scfc_div u_div (
      .clk_i  (clk_i),
      .en_i   (adv),
      .lane_i (lane[a]),
      .quo_o  (quo[a])
    );
  end

  // Delay start and segment vector alongside the dividers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sbd_q[0] <= sb;
      for (int k = 1; k < scfc_pkg::QW; k++) begin
        sbd_q[k] <= sbd_q[k-1];
      end
    end
  end

  scfc_pick u_pick (
    .clk_i  (clk_i),
    .en_i   (adv),
    .quo_i  (quo),
    .sb_i   (sbd_q[scfc_pkg::QW-1]),
    .pick_o (pick)
  );

  scfc_hit u_hit (
    .clk_i     (clk_i),
    .en_i      (adv),
    .pick_i    (pick),
    .crossed_o (crossed),
    .side_o    (side),
    .hit_o     (hit_c)
  );

  assign hit.valid      = vld_q[scfc_pkg::NST-1];
  assign hit.crossed    = crossed;
  assign hit.side_index = side;
  assign hit.hit_x      = hit_c[0];
  assign hit.hit_y      = hit_c[1];
  assign hit.hit_z      = hit_c[2];

  // A missed segment carries an all-zero word
  assign miss_zero = (hit.side_index == 3'(scfc_pkg::FACE_XMIN)) && (hit.hit_x == '0)
                  && (hit.hit_y == '0) && (hit.hit_z == '0);

  // Checks
  `SCFC_ASSERT_NOW(a_miss_zero, hit.valid && !hit.crossed, miss_zero)
  `SCFC_ASSERT_NOW(a_side_range, hit.valid && hit.crossed, hit.side_index <= 3'(scfc_pkg::FACE_ZMAX))
  `SCFC_ASSERT_NOW(a_stall_in, hit.valid && !hit.ready, !seg.ready)
  `SCFC_ASSERT_NEXT(a_enter, seg.valid && seg.ready, vld_q[0])

endmodule

[rtl/scfc_front.sv]
// Size registers and per-axis numerator / denominator setup stage.
module scfc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          cfg_we_i,
  input  logic [scfc_pkg::CIW-1:0]      cfg_idx_i,
  input  logic [scfc_pkg::SW-1:0]       cfg_data_i,
  input  scfc_pkg::coord_t [scfc_pkg::NAX-1:0] st_i,
  input  scfc_pkg::coord_t [scfc_pkg::NAX-1:0] end_i,
  output scfc_pkg::lane_t  [scfc_pkg::NAX-1:0] lane_o,
  output scfc_pkg::segd_t                      sb_o
);

  logic [scfc_pkg::SW-1:0]               size_q [scfc_pkg::NAX];
  scfc_pkg::lane_t [scfc_pkg::NAX-1:0]   lane_q;
  scfc_pkg::segd_t                       sb_q;

  // Write size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q[0] <= scfc_pkg::SIZE_RST;
      size_q[1] <= scfc_pkg::SIZE_RST;
      size_q[2] <= scfc_pkg::SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (scfc_pkg::cfg_reg_e'(cfg_idx_i))
        scfc_pkg::REG_SIZE_X: size_q[0] <= cfg_data_i;
        scfc_pkg::REG_SIZE_Y: size_q[1] <= cfg_data_i;
        scfc_pkg::REG_SIZE_Z: size_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pick the face facing the motion on each axis and form num2, den2
  for (genvar a = 0; a < scfc_pkg::NAX; a++) begin : g_ax
    logic signed [scfc_pkg::DVW-1:0] dv;
    logic        [scfc_pkg::DVW-1:0] dmag;
    logic signed [scfc_pkg::DW-1:0]  szx;
    logic signed [scfc_pkg::DW-1:0]  st2;
    logic signed [scfc_pkg::DW-1:0]  num2;
    logic        [scfc_pkg::DW-1:0]  n;
    logic        [scfc_pkg::DW-1:0]  d;
    logic                            odd;
    logic                            ok;

    assign dv   = scfc_pkg::DVW'(end_i[a]) - scfc_pkg::DVW'(st_i[a]);
    assign dmag = dv[scfc_pkg::DVW-1] ? scfc_pkg::DVW'(-dv) : scfc_pkg::DVW'(dv);
    assign odd  = (dv > 0);
    assign szx  = signed'(scfc_pkg::DW'(size_q[a]));
    assign st2  = scfc_pkg::DW'(st_i[a]) <<< 1;
    assign num2 = odd ? (szx - st2) : (szx + st2);
    assign n    = num2[scfc_pkg::DW-1] ? scfc_pkg::DW'(-num2) : scfc_pkg::DW'(num2);
    assign d    = scfc_pkg::DW'({dmag, 1'b0});
    // drop parallel segments and quotients of magnitude two or more
    assign ok   = (dv != 0) && ({1'b0, n} < {d, 1'b0});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lane_q[a].tag.ok  <= ok;
        lane_q[a].tag.neg <= num2[scfc_pkg::DW-1];
        lane_q[a].tag.odd <= odd;
        lane_q[a].n       <= n;
        lane_q[a].d       <= d;
        sb_q[a].st        <= st_i[a];
        sb_q[a].dv        <= dv;
      end
    end
  end

  assign lane_o = lane_q;
  assign sb_o   = sb_q;

endmodule

[rtl/scfc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module scfc_div (
  input  logic             clk_i,
  input  logic             en_i,
  input  scfc_pkg::lane_t  lane_i,
  output scfc_pkg::quo_t   quo_o
);

  logic [scfc_pkg::DW-1:0] r_q   [scfc_pkg::QW];
  logic [scfc_pkg::DW-1:0] d_q   [scfc_pkg::QW];
  logic [scfc_pkg::QW-1:0] q_q   [scfc_pkg::QW];
  scfc_pkg::tag_t          tag_q [scfc_pkg::QW];

  for (genvar k = 0; k < scfc_pkg::QW; k++) begin : g_st
    logic [scfc_pkg::DW-1:0] r_d;
    logic [scfc_pkg::QW-1:0] q_d;
    logic [scfc_pkg::DW-1:0] dd;
    scfc_pkg::tag_t          tag_d;
    logic                    ge;

    if (k == 0) begin : g_first
      // integer bit: numerator is below twice the divisor
      assign dd    = lane_i.d;
      assign tag_d = lane_i.tag;
      assign ge    = (lane_i.n >= lane_i.d);
      assign r_d   = ge ? (lane_i.n - lane_i.d) : lane_i.n;
      assign q_d   = scfc_pkg::QW'(ge);
    end else begin : g_next
      logic [scfc_pkg::DW:0] r2;
      // shift remainder, subtract when it fits
      assign dd    = d_q[k-1];
      assign tag_d = tag_q[k-1];
      assign r2    = {r_q[k-1], 1'b0};
      assign ge    = (r2 >= {1'b0, d_q[k-1]});
      assign r_d   = ge ? scfc_pkg::DW'(r2 - {1'b0, d_q[k-1]}) : scfc_pkg::DW'(r2);
      assign q_d   = {q_q[k-1][scfc_pkg::QW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= r_d;
        d_q[k]   <= dd;
        q_q[k]   <= q_d;
        tag_q[k] <= tag_d;
      end
    end
  end

  assign quo_o.tag = tag_q[scfc_pkg::QW-1];
  assign quo_o.q   = q_q[scfc_pkg::QW-1];

endmodule

[rtl/scfc_pick.sv]
// Range check on each face parameter and selection of the nearest face.
module scfc_pick (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  scfc_pkg::quo_t [scfc_pkg::NAX-1:0]  quo_i,
  input  scfc_pkg::segd_t                     sb_i,
  output scfc_pkg::pick_t                     pick_o
);

  scfc_pkg::pick_t pick_d;
  scfc_pkg::pick_t pick_q;

  // Scan axes in face order; a tie keeps the earlier face
  always_comb begin
    logic signed [scfc_pkg::SGW-1:0] s;
    logic                            acc;
    pick_d       = '0;
    pick_d.seg   = sb_i;
    pick_d.face  = scfc_pkg::FACE_XMIN;
    for (int a = 0; a < scfc_pkg::NAX; a++) begin
      s = signed'(scfc_pkg::SGW'(quo_i[a].q));
      if (quo_i[a].tag.neg) begin
        s = -s;
      end
      acc = quo_i[a].tag.ok && (s > scfc_pkg::S_LO) && (s < scfc_pkg::S_HI);
      if (acc && (!pick_d.found || (s < pick_d.s))) begin
        pick_d.found = 1'b1;
        pick_d.s     = s;
        pick_d.face  = scfc_pkg::face_e'({2'(a), quo_i[a].tag.odd});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pick_q <= pick_d;
    end
  end

  assign pick_o = pick_q;

endmodule

[rtl/scfc_hit.sv]
// Hit point: scale segment vector by the parameter, add start, saturate.
module scfc_hit (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  scfc_pkg::pick_t                       pick_i,
  output logic                                  crossed_o,
  output logic [2:0]                            side_o,
  output scfc_pkg::coord_t [scfc_pkg::NAX-1:0]  hit_o
);

  logic                              found_q;
  scfc_pkg::face_e                   face_q;
  logic [scfc_pkg::MW-1:0]           mag_q [scfc_pkg::NAX];
  logic                              neg_q [scfc_pkg::NAX];
  scfc_pkg::coord_t                  st_q  [scfc_pkg::NAX];
  logic                              crossed_q;
  logic [2:0]                        side_q;
  scfc_pkg::coord_t [scfc_pkg::NAX-1:0] hit_q;

  // Product stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      found_q <= pick_i.found;
      face_q  <= pick_i.face;
    end
  end

  for (genvar a = 0; a < scfc_pkg::NAX; a++) begin : g_ax
    logic [scfc_pkg::QW-1:0] as;
    logic [scfc_pkg::CW-1:0] ad;
    logic [scfc_pkg::PW-1:0] pf;
    logic [scfc_pkg::MW-1:0] mag;
    logic signed [scfc_pkg::MW:0]   prod;
    logic signed [scfc_pkg::HW-1:0] h;
    logic                            ovf;
    scfc_pkg::coord_t                hs;

    assign as  = pick_i.s[scfc_pkg::SGW-1] ? scfc_pkg::QW'(-pick_i.s)
                                           : scfc_pkg::QW'(pick_i.s);
    assign ad  = pick_i.seg[a].dv[scfc_pkg::DVW-1] ? scfc_pkg::CW'(-pick_i.seg[a].dv)
                                                   : scfc_pkg::CW'(pick_i.seg[a].dv);
    assign pf  = scfc_pkg::PW'(ad) * scfc_pkg::PW'(as[scfc_pkg::PARAM_FRAC_BITS-1:0]);
    assign mag = (as[scfc_pkg::PARAM_FRAC_BITS] ? scfc_pkg::MW'(ad) : '0)
               + scfc_pkg::MW'(pf[scfc_pkg::PW-1:scfc_pkg::PARAM_FRAC_BITS]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mag_q[a] <= mag;
        neg_q[a] <= pick_i.seg[a].dv[scfc_pkg::DVW-1] ^ pick_i.s[scfc_pkg::SGW-1];
        st_q[a]  <= pick_i.seg[a].st;
      end
    end

    // Add start and clamp to the coordinate range
    assign prod = neg_q[a] ? -signed'({1'b0, mag_q[a]}) : signed'({1'b0, mag_q[a]});
    assign h    = scfc_pkg::HW'(st_q[a]) + scfc_pkg::HW'(prod);
    assign ovf  = (h[scfc_pkg::HW-1:scfc_pkg::CW-1] != '0)
               && (h[scfc_pkg::HW-1:scfc_pkg::CW-1] != '1);
    assign hs   = !ovf ? scfc_pkg::coord_t'(h[scfc_pkg::CW-1:0])
                : h[scfc_pkg::HW-1] ? {1'b1, {(scfc_pkg::CW-1){1'b0}}}
                                    : {1'b0, {(scfc_pkg::CW-1){1'b1}}};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        hit_q[a] <= found_q ? hs : '0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      crossed_q <= found_q;
      side_q    <= found_q ? 3'(face_q) : 3'(scfc_pkg::FACE_XMIN);
    end
  end

  assign crossed_o = crossed_q;
  assign side_o    = side_q;
  assign hit_o     = hit_q;

endmodule
